/* sv/gcvs_pkg.sv */
// Shared widths, pipeline sizes and types for the guiding-center velocity shear unit.
package gcvs_pkg;

    localparam int WordWidth = 32;
    localparam int FracBits  = 16;
    localparam int LenWidth  = WordWidth - 1;
    localparam int YsumWidth = 49;
    localparam int ModSteps  = YsumWidth;
    localparam int DivSteps  = WordWidth - 1;
    localparam int KWidth    = 36;

    localparam logic [2:0] CFG_CELL_SIZE_Y    = 3'd0;
    localparam logic [2:0] CFG_RADIUS_SCALE_Z = 3'd1;
    localparam logic [2:0] CFG_GRID_VEL_SCALE = 3'd2;
    localparam logic [2:0] CFG_BOX_LENGTH_Y   = 3'd3;
    localparam logic [2:0] CFG_SHEAR_MAX      = 3'd4;
    localparam logic [2:0] CFG_PERP_ENABLED   = 3'd5;

    localparam logic [1:0] REGION_OUTER   = 2'd0;
    localparam logic [1:0] REGION_RISING  = 2'd1;
    localparam logic [1:0] REGION_CREST   = 2'd2;
    localparam logic [1:0] REGION_FALLING = 2'd3;

    typedef struct packed {
        logic signed [WordWidth-1:0] vel_x;
        logic                        last;
        logic [1:0]                  region;
    } side_t;

endpackage

/* sv/gcvs_mod_pipe.sv */
// Pipelined unsigned remainder unit, one dividend bit per stage.
module gcvs_mod_pipe (
    input  logic                              aclk,
    input  logic                              en,
    input  logic [gcvs_pkg::YsumWidth-1:0]    dividend,
    input  logic                              neg_in,
    input  logic [gcvs_pkg::LenWidth-1:0]     divisor,
    output logic [gcvs_pkg::LenWidth-1:0]     remainder,
    output logic                              neg_out
);

    localparam int N = gcvs_pkg::ModSteps;
    localparam int W = gcvs_pkg::LenWidth;
    localparam int D = gcvs_pkg::YsumWidth;

    logic [W-1:0] rem_reg [N];
    logic [D-1:0] dvd_reg [N];
    logic         neg_reg [N];

    for (genvar i = 0; i < N; i++) begin : g_step
        logic [W-1:0] rem_prev;
        logic [D-1:0] dvd_prev;
        logic         neg_prev;
        logic [W:0]   trial;
        logic [W-1:0] rem_next;

        always_comb begin
            if (i == 0) begin
                rem_prev = '0;
                dvd_prev = dividend;
                neg_prev = neg_in;
            end else begin
                rem_prev = rem_reg[(i == 0) ? 0 : i-1];
                dvd_prev = dvd_reg[(i == 0) ? 0 : i-1];
                neg_prev = neg_reg[(i == 0) ? 0 : i-1];
            end
            trial = {rem_prev, dvd_prev[D-1]};
            if (trial >= {1'b0, divisor}) begin
                rem_next = W'(trial - {1'b0, divisor});
            end else begin
                rem_next = trial[W-1:0];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i] <= rem_next;
                dvd_reg[i] <= {dvd_prev[D-2:0], 1'b0};
                neg_reg[i] <= neg_prev;
            end
        end
    end

    assign remainder = rem_reg[N-1];
    assign neg_out   = neg_reg[N-1];

endmodule

/* sv/guiding_center_velocity_shear_unit.sv */
// Top level: guiding-center wrap, trapezoid shear profile and velocity update.
//
//   channel  direction  handshake            payload
//   s_       in         s_valid / s_ready    s_pos_y s_vel_x s_vel_y s_vel_z s_last_in
//   m_       out        m_valid / m_ready    m_new_vel_x m_region m_last_out
//   cfg_     in         cfg_valid/cfg_ready  cfg_index cfg_data
//
// One request enters per cycle unless the output waits; data passes through the
// 49-stage remainder unit and the 31-stage profile divider, one bit per stage each.
// Reset clears the stage valid bits and restores register defaults.
// When the output waits, the whole pipeline holds, and input is refused that cycle.
module guiding_center_velocity_shear_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_pos_y,
    input  logic [31:0] s_vel_x,
    input  logic [31:0] s_vel_y,
    input  logic [31:0] s_vel_z,
    input  logic        s_last_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_new_vel_x,
    output logic [1:0]  m_region,
    output logic        m_last_out,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int WW   = gcvs_pkg::WordWidth;
    localparam int FB   = gcvs_pkg::FracBits;
    localparam int LW   = gcvs_pkg::LenWidth;
    localparam int YW   = gcvs_pkg::YsumWidth;
    localparam int KW   = gcvs_pkg::KWidth;
    localparam int DS   = gcvs_pkg::DivSteps;
    localparam int ST_MOD_END = 1 + gcvs_pkg::ModSteps;
    localparam int ST_YC      = ST_MOD_END + 1;
    localparam int ST_K       = ST_YC + 1;
    localparam int ST_PK      = ST_K + 1;
    localparam int ST_ABS     = ST_PK + 1;
    localparam int ST_DIV_END = ST_ABS + DS;
    localparam int ST_PROF    = ST_DIV_END + 1;
    localparam int ST_PG      = ST_PROF + 1;
    localparam int ST_OUT     = ST_PG + 1;
    localparam int NST        = ST_OUT + 1;

    logic [LW-1:0]        cell_reg;
    logic signed [WW-1:0] rscale_reg;
    logic signed [WW-1:0] gscale_reg;
    logic [LW-1:0]        len_reg;
    logic signed [WW-1:0] shear_reg;
    logic                 perp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg   <= LW'(1) << FB;
            rscale_reg <= '0;
            gscale_reg <= WW'(1) << FB;
            len_reg    <= LW'(1) << FB;
            shear_reg  <= '0;
            perp_reg   <= 1'b1;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                gcvs_pkg::CFG_CELL_SIZE_Y:    cell_reg   <= cfg_data[LW-1:0];
                gcvs_pkg::CFG_RADIUS_SCALE_Z: rscale_reg <= cfg_data;
                gcvs_pkg::CFG_GRID_VEL_SCALE: gscale_reg <= cfg_data;
                gcvs_pkg::CFG_BOX_LENGTH_Y:   len_reg    <= cfg_data[LW-1:0];
                gcvs_pkg::CFG_SHEAR_MAX:      shear_reg  <= cfg_data;
                gcvs_pkg::CFG_PERP_ENABLED:   perp_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    logic [LW-1:0] len_eff;
    logic [LW:0]   len2;
    assign len_eff = (len_reg == '0) ? LW'(1) : len_reg;
    assign len2    = {len_eff, 1'b0};

    logic en;
    logic vld_reg [NST];
    gcvs_pkg::side_t side_reg [NST];
    logic [1:0] region_next;

    assign en      = !vld_reg[NST-1] || m_ready;
    assign s_ready = en;

    for (genvar i = 0; i < NST; i++) begin : g_ctl
        gcvs_pkg::side_t side_in;
        always_comb begin
            if (i == 0) begin
                side_in = '{vel_x: s_vel_x, last: s_last_in, region: gcvs_pkg::REGION_OUTER};
            end else begin
                side_in = side_reg[(i == 0) ? 0 : i-1];
                if (i == ST_K) begin
                    side_in.region = region_next;
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (en) begin
                vld_reg[i] <= (i == 0) ? s_valid : vld_reg[(i == 0) ? 0 : i-1];
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[i] <= side_in;
            end
        end
    end

    logic signed [63:0] prod_y_reg, prod_z_reg;
    logic               gate_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_y_reg <= $signed(s_pos_y) * $signed({33'd0, cell_reg});
            prod_z_reg <= $signed(s_vel_z) * rscale_reg;
            gate_reg   <= perp_reg && (s_vel_y != '0 || s_vel_z != '0);
        end
    end

    logic signed [YW-1:0] ysum;
    logic [YW-1:0]        ymag_reg;
    logic                 yneg_reg;
    always_comb begin
        ysum = YW'(prod_y_reg >>> FB);
        if (gate_reg) begin
            ysum = ysum + YW'(prod_z_reg >>> FB);
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            yneg_reg <= ysum[YW-1];
            ymag_reg <= ysum[YW-1] ? YW'(-ysum) : ysum;
        end
    end

    logic [LW-1:0] mod_rem;
    logic          mod_neg;
    gcvs_mod_pipe u_mod (
        .aclk      (aclk),
        .en        (en),
        .dividend  (ymag_reg),
        .neg_in    (yneg_reg),
        .divisor   (len_eff),
        .remainder (mod_rem),
        .neg_out   (mod_neg)
    );

    logic [LW-1:0] yc_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            yc_reg <= (mod_neg && mod_rem != '0) ? LW'(len_eff - mod_rem) : mod_rem;
        end
    end

    logic [KW-1:0]        yc_w, len_w;
    logic signed [KW-1:0] k_next, k_reg;
    always_comb begin
        yc_w = KW'(yc_reg);
        len_w = KW'(len_eff);
        if (6 * yc_w <= len_w || 6 * yc_w >= 5 * len_w) begin
            region_next = gcvs_pkg::REGION_OUTER;
            k_next = -$signed(len_w);
        end else if (3 * yc_w <= len_w) begin
            region_next = gcvs_pkg::REGION_RISING;
            k_next = $signed(12 * yc_w - 3 * len_w);
        end else if (3 * yc_w <= 2 * len_w) begin
            region_next = gcvs_pkg::REGION_CREST;
            k_next = $signed(len_w);
        end else begin
            region_next = gcvs_pkg::REGION_FALLING;
            k_next = $signed(9 * len_w - 12 * yc_w);
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            k_reg <= k_next;
        end
    end

    logic signed [WW+KW-1:0] pk_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            pk_reg <= shear_reg * k_reg;
        end
    end

    logic [63:0] pmag_reg;
    logic        pneg_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            pneg_reg <= pk_reg[WW+KW-1];
            pmag_reg <= 64'(pk_reg[WW+KW-1] ? -pk_reg : pk_reg);
        end
    end

    logic [LW:0]   drem_reg [DS];
    logic [DS-1:0] dlow_reg [DS];
    logic [DS-1:0] dq_reg   [DS];
    logic          dneg_reg [DS];

    for (genvar i = 0; i < DS; i++) begin : g_div
        logic [LW:0]   rem_prev, rem_next;
        logic [DS-1:0] low_prev, q_prev;
        logic          neg_prev;
        logic [LW+1:0] trial;
        logic          take;
        always_comb begin
            if (i == 0) begin
                rem_prev = pmag_reg[DS+LW:DS];
                low_prev = pmag_reg[DS-1:0];
                q_prev   = '0;
                neg_prev = pneg_reg;
            end else begin
                rem_prev = drem_reg[(i == 0) ? 0 : i-1];
                low_prev = dlow_reg[(i == 0) ? 0 : i-1];
                q_prev   = dq_reg[(i == 0) ? 0 : i-1];
                neg_prev = dneg_reg[(i == 0) ? 0 : i-1];
            end
            trial = {rem_prev, low_prev[DS-1]};
            take  = trial >= {1'b0, len2};
            rem_next = take ? (LW+1)'(trial - {1'b0, len2}) : trial[LW:0];
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                drem_reg[i] <= rem_next;
                dlow_reg[i] <= {low_prev[DS-2:0], 1'b0};
                dq_reg[i]   <= {q_prev[DS-2:0], take};
                dneg_reg[i] <= neg_prev;
            end
        end
    end

    logic signed [WW-1:0] prof_reg;
    logic signed [WW-1:0] qs;
    always_comb begin
        qs = $signed({1'b0, dq_reg[DS-1]});
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            if (dneg_reg[DS-1]) begin
                prof_reg <= -qs - ((drem_reg[DS-1] != '0) ? WW'(1) : WW'(0));
            end else begin
                prof_reg <= qs;
            end
        end
    end

    logic signed [2*WW-1:0] pg_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            pg_reg <= prof_reg * gscale_reg;
        end
    end

    localparam int SW = 2 * WW - FB + 1;
    logic signed [SW-1:0] sum;
    logic signed [WW-1:0] res;
    logic signed [SW-1:0] sat_hi, sat_lo;
    always_comb begin
        sat_hi = SW'({1'b0, {(WW-1){1'b1}}});
        sat_lo = -sat_hi - SW'(1);
        sum = SW'(side_reg[ST_PG].vel_x) + SW'(pg_reg >>> FB);
        if (sum > sat_hi) begin
            res = sat_hi[WW-1:0];
        end else if (sum < sat_lo) begin
            res = sat_lo[WW-1:0];
        end else begin
            res = sum[WW-1:0];
        end
    end

    logic signed [WW-1:0] out_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= res;
        end
    end

    assign m_valid     = vld_reg[NST-1];
    assign m_new_vel_x = out_reg;
    assign m_region    = side_reg[NST-1].region;
    assign m_last_out  = side_reg[NST-1].last;

    a_refuse_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready) else $error("input refused with empty output stage");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(m_new_vel_x) && $stable(m_region))
        else $error("output changed during stall");

    a_wrap_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[ST_YC] |-> yc_reg < len_eff) else $error("wrapped position out of box");

    a_prof_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[ST_DIV_END] |-> drem_reg[DS-1] < len2) else $error("divider remainder too big");

endmodule

/* test/tb.sv */
// Self-checking testbench for the guiding-center velocity shear unit.
`timescale 1ns / 100ps

module tb;

    localparam int HalfPeriod = 6;
    localparam int Latency    = 89;
    localparam int StallLimit = 20000;

    typedef struct {
        logic [31:0] pos_y;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [31:0] vel_z;
        logic        last;
        bit          typed;
        logic [31:0] exp_vel_x;
        logic [1:0]  exp_region;
    } stim_row_t;

    typedef struct {
        logic [31:0] vel_x;
        logic [1:0]  region;
        logic        last;
    } sheared_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_pos_y = '0;
    logic [31:0] s_vel_x = '0;
    logic [31:0] s_vel_y = '0;
    logic [31:0] s_vel_z = '0;
    logic        s_last_in = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_new_vel_x;
    logic [1:0]  m_region;
    logic        m_last_out;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    logic [30:0] cell_size;
    logic [31:0] radius_scale;
    logic [31:0] vel_scale;
    logic [30:0] box_length;
    logic [31:0] shear_amp;
    logic        perp_on;

    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;
    int       errors = 0;
    int       quiet_cycles = 0;
    sheared_t expected_particles[$];

    always #HalfPeriod aclk = ~aclk;

    guiding_center_velocity_shear_unit u_top (.*);

    function automatic longint floor_shift(longint v);
        return v >>> gcvs_pkg::FracBits;
    endfunction

    function automatic sheared_t shear_particle(logic [31:0] pos_y, logic [31:0] vel_x,
                                                logic [31:0] vel_y, logic [31:0] vel_z,
                                                logic last);
        sheared_t r;
        longint len, ysum, yc, k, num, prof, sum;
        logic [1:0] reg_code;
        len = longint'(box_length);
        if (len < 1) begin
            len = 1;
        end
        ysum = floor_shift(longint'($signed(pos_y)) * longint'(cell_size));
        if (perp_on && (vel_y != 0 || vel_z != 0)) begin
            ysum += floor_shift(longint'($signed(vel_z)) * longint'($signed(radius_scale)));
        end
        yc = ysum % len;
        if (yc < 0) begin
            yc += len;
        end
        if (6 * yc <= len || 6 * yc >= 5 * len) begin
            reg_code = gcvs_pkg::REGION_OUTER;
            k = -len;
        end else if (3 * yc <= len) begin
            reg_code = gcvs_pkg::REGION_RISING;
            k = 12 * yc - 3 * len;
        end else if (3 * yc <= 2 * len) begin
            reg_code = gcvs_pkg::REGION_CREST;
            k = len;
        end else begin
            reg_code = gcvs_pkg::REGION_FALLING;
            k = 9 * len - 12 * yc;
        end
        num = longint'($signed(shear_amp)) * k;
        prof = num / (2 * len);
        if (num % (2 * len) != 0 && num < 0) begin
            prof -= 1;
        end
        sum = longint'($signed(vel_x)) + floor_shift(prof * longint'($signed(vel_scale)));
        if (sum > 64'sd2147483647) begin
            sum = 64'sd2147483647;
        end
        if (sum < -64'sd2147483648) begin
            sum = -64'sd2147483648;
        end
        r.vel_x = sum[31:0];
        r.region = reg_code;
        r.last = last;
        return r;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            gcvs_pkg::CFG_CELL_SIZE_Y:    cell_size = data[30:0];
            gcvs_pkg::CFG_RADIUS_SCALE_Z: radius_scale = data;
            gcvs_pkg::CFG_GRID_VEL_SCALE: vel_scale = data;
            gcvs_pkg::CFG_BOX_LENGTH_Y:   box_length = data[30:0];
            gcvs_pkg::CFG_SHEAR_MAX:      shear_amp = data;
            gcvs_pkg::CFG_PERP_ENABLED:   perp_on = data[0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        while (expected_particles.size() != 0) begin
            @(posedge aclk);
        end
        repeat (Latency + 6) @(posedge aclk);
    endtask

    task automatic send_particle(stim_row_t row);
        sheared_t e;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pos_y <= row.pos_y;
        s_vel_x <= row.vel_x;
        s_vel_y <= row.vel_y;
        s_vel_z <= row.vel_z;
        s_last_in <= row.last;
        do @(posedge aclk); while (!s_ready);
        if (row.typed) begin
            e.vel_x = row.exp_vel_x;
            e.region = row.exp_region;
            e.last = row.last;
        end else begin
            e = shear_particle(row.pos_y, row.vel_x, row.vel_y, row.vel_z, row.last);
        end
        expected_particles.push_back(e);
    endtask

    task automatic walk_table(stim_row_t rows[]);
        foreach (rows[i]) begin
            send_particle(rows[i]);
        end
        s_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(5))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return $urandom_range(65536 * 8);
            3: return -$urandom_range(65536 * 8);
            default: return $urandom;
        endcase
    endfunction

    task automatic random_config(int variant);
        write_reg(gcvs_pkg::CFG_CELL_SIZE_Y, (variant == 0) ? 32'h7fff_ffff : pick_word());
        write_reg(gcvs_pkg::CFG_RADIUS_SCALE_Z, (variant == 1) ? 32'h8000_0000 : pick_word());
        write_reg(gcvs_pkg::CFG_GRID_VEL_SCALE, (variant == 2) ? 32'h7fff_ffff : pick_word());
        case (variant)
            3: write_reg(gcvs_pkg::CFG_BOX_LENGTH_Y, 32'd0);
            4: write_reg(gcvs_pkg::CFG_BOX_LENGTH_Y, 32'h7fff_ffff);
            5: write_reg(gcvs_pkg::CFG_BOX_LENGTH_Y, 32'd1);
            default: write_reg(gcvs_pkg::CFG_BOX_LENGTH_Y, $urandom_range(65536 * 64, 1));
        endcase
        write_reg(gcvs_pkg::CFG_SHEAR_MAX, (variant == 1) ? 32'h8000_0000 : pick_word());
        write_reg(gcvs_pkg::CFG_PERP_ENABLED, {$urandom} & 32'h3);
        write_reg(3'd6 + variant[0], $urandom);
    endtask

    task automatic random_particles(int count);
        stim_row_t row;
        repeat (count) begin
            row.pos_y = pick_word();
            row.vel_x = pick_word();
            row.vel_y = ($urandom_range(3) == 0) ? 32'd0 : pick_word();
            row.vel_z = ($urandom_range(3) == 0) ? 32'd0 : pick_word();
            row.last = 1'($urandom_range(1));
            row.typed = 1'b0;
            send_particle(row);
        end
        s_valid <= 1'b0;
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        sheared_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_particles.size() == 0) begin
                $display("%0t: unexpected result vel_x=%h region=%0d", $time, m_new_vel_x,
                         m_region);
                errors++;
            end else begin
                e = expected_particles.pop_front();
                if (m_new_vel_x !== e.vel_x) begin
                    $display("%0t: new_vel_x expected %h actual %h", $time, e.vel_x,
                             m_new_vel_x);
                    errors++;
                end
                if (m_region !== e.region) begin
                    $display("%0t: region expected %0d actual %0d", $time, e.region, m_region);
                    errors++;
                end
                if (m_last_out !== e.last) begin
                    $display("%0t: last_out expected %b actual %b", $time, e.last, m_last_out);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= StallLimit) begin
            $display("tb: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        stim_row_t reset_rows[];
        stim_row_t profile_rows[];
        cell_size = 31'h1_0000;
        radius_scale = '0;
        vel_scale = 32'h1_0000;
        box_length = 31'h1_0000;
        shear_amp = '0;
        perp_on = 1'b1;

        // With the reset settings the amplitude is zero and y = 0 lands in the outer region.
        reset_rows = '{
            '{32'h0, 32'h7fff_ffff, 32'h0, 32'h0, 1'b0, 1'b1, 32'h7fff_ffff,
              gcvs_pkg::REGION_OUTER},
            '{32'h0, 32'h8000_0000, 32'h1, 32'h0, 1'b1, 1'b1, 32'h8000_0000,
              gcvs_pkg::REGION_OUTER},
            '{32'h0, 32'h0, 32'hffff_ffff, 32'h7fff_ffff, 1'b0, 1'b1, 32'h0,
              gcvs_pkg::REGION_OUTER},
            '{32'h0, 32'h1234_5678, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b1,
              32'h1234_5678, gcvs_pkg::REGION_OUTER}
        };
        // Box of 6.0 puts the region edges on whole units of y.
        profile_rows = '{
            '{32'h1_0000, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0, gcvs_pkg::REGION_OUTER},
            '{32'h1_0001, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0, gcvs_pkg::REGION_OUTER},
            '{32'h2_0000, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0, gcvs_pkg::REGION_OUTER},
            '{32'h2_0001, 32'h0, 32'h0, 32'h0, 1'b1, 1'b0, 32'h0, gcvs_pkg::REGION_OUTER},
            '{32'h4_0000, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0, gcvs_pkg::REGION_OUTER},
            '{32'h4_0001, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0, gcvs_pkg::REGION_OUTER},
            '{32'h4_ffff, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0, gcvs_pkg::REGION_OUTER},
            '{32'h5_0000, 32'h0, 32'h0, 32'h0, 1'b1, 1'b0, 32'h0, gcvs_pkg::REGION_OUTER},
            '{32'hffff_0000, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0, gcvs_pkg::REGION_OUTER},
            '{32'h0, 32'h0, 32'h0, 32'h3_0000, 1'b0, 1'b0, 32'h0, gcvs_pkg::REGION_OUTER},
            '{32'h0, 32'h0, 32'h1, 32'hfffd_0000, 1'b0, 1'b0, 32'h0, gcvs_pkg::REGION_OUTER},
            '{32'h3_0000, 32'h7fff_ffff, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0,
              gcvs_pkg::REGION_OUTER},
            '{32'h0, 32'h8000_0000, 32'h0, 32'h0, 1'b1, 1'b0, 32'h0, gcvs_pkg::REGION_OUTER},
            '{32'h8000_0000, 32'h7fff_0000, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0,
              gcvs_pkg::REGION_OUTER},
            '{32'h7fff_ffff, 32'h8000_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1, 1'b0, 32'h0,
              gcvs_pkg::REGION_OUTER}
        };

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        walk_table(reset_rows);
        wait_drained();

        write_reg(gcvs_pkg::CFG_BOX_LENGTH_Y, 32'h6_0000);
        write_reg(gcvs_pkg::CFG_SHEAR_MAX, 32'h7fff_ffff);
        write_reg(gcvs_pkg::CFG_GRID_VEL_SCALE, 32'h7fff_ffff);
        write_reg(gcvs_pkg::CFG_RADIUS_SCALE_Z, 32'h1_0000);
        walk_table(profile_rows);
        wait_drained();
        write_reg(gcvs_pkg::CFG_PERP_ENABLED, 32'h0);
        write_reg(gcvs_pkg::CFG_SHEAR_MAX, 32'h8000_0000);
        walk_table(profile_rows);
        wait_drained();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
                1: begin send_idle_pct = 81; recv_idle_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_idle_pct = 81; end
                default: begin send_idle_pct = 14; recv_idle_pct = 14; end
            endcase
            random_config(phase);
            random_particles(90);
            wait_drained();
        end

        if (errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
